FILE: sv/cwb_pkg.sv
// ----------------------------------------------------------------------------
// cwb_pkg
// Shared constants, types and saturation helpers for the circular wall bounce
// ----------------------------------------------------------------------------
package cwb_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int NORM_BITS   = 30;
  localparam int EPS_LSB     = (1 << FRAC_BITS) / 1000000;
  localparam int DIST_W      = 34;
  localparam int SUMSQ_W     = 66;
  localparam int SQRT_STAGES = DIST_W;
  localparam int QUOT_W      = NORM_BITS + 1;
  localparam int DIV_STAGES  = QUOT_W;
  localparam int SAT_W       = 36;
  localparam int CFG_IDX_W   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_BOUND_RADIUS = 3'd2,
    REG_BOUNCE_COEFF = 3'd3,
    REG_CENTRE_PULL  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [30:0]        bound_radius;
    logic [15:0]        bounce_coeff;
    logic [15:0]        centre_pull;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] maxd;
  } body_t;

  localparam logic signed [SAT_W-1:0] SAT_MAX = 36'sh07FFFFFFF;
  localparam logic signed [SAT_W-1:0] SAT_MIN = 36'shF80000000;

  function automatic logic ovf32(input logic signed [SAT_W-1:0] v);
    return (v > SAT_MAX) || (v < SAT_MIN);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (v < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: sv/circular_wall_bounce.sv
// ----------------------------------------------------------------------------
// circular_wall_bounce
// Keeps one body inside a circular world: reflect, clamp and pull to centre
// ----------------------------------------------------------------------------
// channel  direction  handshake                 payload
// in       input      in_valid / in_stall       pos_x pos_y vel_x vel_y body_radius
// out      output     out_valid / out_stall     new_pos/new_vel x,y and flags
// cfg      input      cfg_valid / cfg_ready     cfg_index cfg_data
//
// one word per cycle while out_stall does not hold the pipe; 34 root stages and
// 31 divider stages plus 3 front and 6 resolve stages
// one enable moves every stage; a stalled output word freezes the whole pipe
// rst clears the valid bits and loads the register defaults
// ----------------------------------------------------------------------------
module circular_wall_bounce (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [31:0]               pos_x,
  input  logic signed [31:0]               pos_y,
  input  logic signed [31:0]               vel_x,
  input  logic signed [31:0]               vel_y,
  input  logic [30:0]                      body_radius,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [31:0]               new_pos_x,
  output logic signed [31:0]               new_pos_y,
  output logic signed [31:0]               new_vel_x,
  output logic signed [31:0]               new_vel_y,
  output logic                             was_clamped,
  output logic                             was_reflected,
  output logic                             saturated,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cwb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                      cfg_data
);
  import cwb_pkg::*;

  cfg_t              cfg;
  logic              en;
  logic              f_valid, s_valid, d_valid, d_outside;
  body_t             f_body, s_body, d_body;
  logic [SUMSQ_W-1:0] f_sumsq;
  logic [DIST_W-1:0] s_dist;
  logic [QUOT_W-1:0] d_qx, d_qy;

  assign cfg_ready = 1'b1;
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x     <= 32'sd0;
      cfg.center_y     <= 32'sd0;
      cfg.bound_radius <= 31'd65536000;
      cfg.bounce_coeff <= 16'd60948;
      cfg.centre_pull  <= 16'd429;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CENTER_X:     cfg.center_x     <= cfg_data;
        REG_CENTER_Y:     cfg.center_y     <= cfg_data;
        REG_BOUND_RADIUS: cfg.bound_radius <= cfg_data[30:0];
        REG_BOUNCE_COEFF: cfg.bounce_coeff <= cfg_data[15:0];
        REG_CENTRE_PULL:  cfg.centre_pull  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  cwb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .vel_x      (vel_x),
    .vel_y      (vel_y),
    .body_radius(body_radius),
    .out_valid  (f_valid),
    .out_body   (f_body),
    .out_sumsq  (f_sumsq)
  );

  cwb_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (f_valid),
    .in_body  (f_body),
    .in_sumsq (f_sumsq),
    .out_valid(s_valid),
    .out_body (s_body),
    .out_dist (s_dist)
  );

  cwb_div u_div (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (s_valid),
    .in_body    (s_body),
    .in_dist    (s_dist),
    .out_valid  (d_valid),
    .out_body   (d_body),
    .out_outside(d_outside),
    .out_qx     (d_qx),
    .out_qy     (d_qy)
  );

  cwb_resolve u_resolve (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .cfg          (cfg),
    .in_valid     (d_valid),
    .in_body      (d_body),
    .in_outside   (d_outside),
    .in_qx        (d_qx),
    .in_qy        (d_qy),
    .out_valid    (out_valid),
    .new_pos_x    (new_pos_x),
    .new_pos_y    (new_pos_y),
    .new_vel_x    (new_vel_x),
    .new_vel_y    (new_vel_y),
    .was_clamped  (was_clamped),
    .was_reflected(was_reflected),
    .saturated    (saturated)
  );

endmodule

FILE: sv/cwb_front.sv
// ----------------------------------------------------------------------------
// cwb_front
// Offset from centre, squared components and their sum, three stages
// ----------------------------------------------------------------------------
module cwb_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  cwb_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  input  logic signed [31:0]            pos_x,
  input  logic signed [31:0]            pos_y,
  input  logic signed [31:0]            vel_x,
  input  logic signed [31:0]            vel_y,
  input  logic [30:0]                   body_radius,
  output logic                          out_valid,
  output cwb_pkg::body_t                out_body,
  output logic [cwb_pkg::SUMSQ_W-1:0]   out_sumsq
);
  import cwb_pkg::*;

  function automatic logic [SUMSQ_W-1:0] sq33(input logic [32:0] a);
    logic [63:0] p;
    p = 64'(a[31:0]) * 64'(a[31:0]);
    return 66'(p) + (a[32] ? ({1'b0, a[31:0], 33'd0} + {2'b01, 64'd0}) : 66'd0);
  endfunction

  logic               vld1, vld2, vld3;
  body_t              bd1, bd2, bd3;
  logic [32:0]        ax, ay;
  logic [SUMSQ_W-1:0] sqx, sqy, sumsq;

  assign ax = bd1.dx[32] ? 33'(-bd1.dx) : 33'(bd1.dx);
  assign ay = bd1.dy[32] ? 33'(-bd1.dy) : 33'(bd1.dy);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
    end else if (en) begin
      vld1 <= in_valid;
      vld2 <= vld1;
      vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bd1.px   <= pos_x;
      bd1.py   <= pos_y;
      bd1.vx   <= vel_x;
      bd1.vy   <= vel_y;
      bd1.dx   <= 33'(pos_x) - 33'(cfg.center_x);
      bd1.dy   <= 33'(pos_y) - 33'(cfg.center_y);
      bd1.maxd <= $signed({2'b00, cfg.bound_radius}) - $signed({2'b00, body_radius});
      bd2      <= bd1;
      sqx      <= sq33(ax);
      sqy      <= sq33(ay);
      bd3      <= bd2;
      sumsq    <= sqx + sqy;
    end
  end

  assign out_valid = vld3;
  assign out_body  = bd3;
  assign out_sumsq = sumsq;

endmodule

FILE: sv/cwb_sqrt.sv
// ----------------------------------------------------------------------------
// cwb_sqrt
// Integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module cwb_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  cwb_pkg::body_t                in_body,
  input  logic [cwb_pkg::SUMSQ_W-1:0]   in_sumsq,
  output logic                          out_valid,
  output cwb_pkg::body_t                out_body,
  output logic [cwb_pkg::DIST_W-1:0]    out_dist
);
  import cwb_pkg::*;

  logic              vld  [0:SQRT_STAGES];
  body_t             bd   [0:SQRT_STAGES];
  logic [67:0]       rad  [0:SQRT_STAGES];
  logic [36:0]       rem  [0:SQRT_STAGES];
  logic [DIST_W-1:0] root [0:SQRT_STAGES];

  assign vld[0]  = in_valid;
  assign bd[0]   = in_body;
  assign rad[0]  = {2'b00, in_sumsq};
  assign rem[0]  = '0;
  assign root[0] = '0;

  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
    logic [36:0] rem_s, trial;

    always_comb begin
      rem_s = {rem[i][34:0], rad[i][67:66]};
      trial = {1'b0, root[i], 2'b01};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        bd[i+1]  <= bd[i];
        rad[i+1] <= {rad[i][65:0], 2'b00};
        if (rem_s >= trial) begin
          rem[i+1]  <= rem_s - trial;
          root[i+1] <= {root[i][DIST_W-2:0], 1'b1};
        end else begin
          rem[i+1]  <= rem_s;
          root[i+1] <= {root[i][DIST_W-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld[SQRT_STAGES];
  assign out_body  = bd[SQRT_STAGES];
  assign out_dist  = root[SQRT_STAGES];

  a_sqrt_rem_bound: assert property (@(posedge clk) disable iff (rst)
    vld[SQRT_STAGES] |-> rem[SQRT_STAGES] <= {2'b00, root[SQRT_STAGES], 1'b0})
    else $error("square root remainder above twice the root");

endmodule

FILE: sv/cwb_div.sv
// ----------------------------------------------------------------------------
// cwb_div
// Outside test and unit normal magnitudes, restoring division per stage
// ----------------------------------------------------------------------------
module cwb_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  cwb_pkg::body_t                in_body,
  input  logic [cwb_pkg::DIST_W-1:0]    in_dist,
  output logic                          out_valid,
  output cwb_pkg::body_t                out_body,
  output logic                          out_outside,
  output logic [cwb_pkg::QUOT_W-1:0]    out_qx,
  output logic [cwb_pkg::QUOT_W-1:0]    out_qy
);
  import cwb_pkg::*;

  logic              vld  [0:DIV_STAGES];
  body_t             bd   [0:DIV_STAGES];
  logic [DIST_W-1:0] dvsr [0:DIV_STAGES];
  logic              outs [0:DIV_STAGES];
  logic [34:0]       remx [0:DIV_STAGES];
  logic [34:0]       remy [0:DIV_STAGES];
  logic [QUOT_W-1:0] qx   [0:DIV_STAGES];
  logic [QUOT_W-1:0] qy   [0:DIV_STAGES];

  logic [32:0] ax, ay;

  assign ax = in_body.dx[32] ? 33'(-in_body.dx) : 33'(in_body.dx);
  assign ay = in_body.dy[32] ? 33'(-in_body.dy) : 33'(in_body.dy);

  assign vld[0]  = in_valid;
  assign bd[0]   = in_body;
  assign dvsr[0] = in_dist;
  assign outs[0] = ($signed({1'b0, in_dist}) > $signed({{2{in_body.maxd[32]}}, in_body.maxd}))
                   && (in_dist > DIST_W'(EPS_LSB));
  assign remx[0] = {2'b00, ax};
  assign remy[0] = {2'b00, ay};
  assign qx[0]   = '0;
  assign qy[0]   = '0;

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    logic [34:0] tx, ty, dv;

    always_comb begin
      dv = {1'b0, dvsr[i]};
      if (i == 0) begin
        tx = remx[i];
        ty = remy[i];
      end else begin
        tx = {remx[i][33:0], 1'b0};
        ty = {remy[i][33:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        bd[i+1]   <= bd[i];
        dvsr[i+1] <= dvsr[i];
        outs[i+1] <= outs[i];
        if (tx >= dv) begin
          remx[i+1] <= tx - dv;
          qx[i+1]   <= {qx[i][QUOT_W-2:0], 1'b1};
        end else begin
          remx[i+1] <= tx;
          qx[i+1]   <= {qx[i][QUOT_W-2:0], 1'b0};
        end
        if (ty >= dv) begin
          remy[i+1] <= ty - dv;
          qy[i+1]   <= {qy[i][QUOT_W-2:0], 1'b1};
        end else begin
          remy[i+1] <= ty;
          qy[i+1]   <= {qy[i][QUOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid   = vld[DIV_STAGES];
  assign out_body    = bd[DIV_STAGES];
  assign out_outside = outs[DIV_STAGES];
  assign out_qx      = qx[DIV_STAGES];
  assign out_qy      = qy[DIV_STAGES];

  a_div_rem_below: assert property (@(posedge clk) disable iff (rst)
    vld[DIV_STAGES] && outs[DIV_STAGES] |->
      (remx[DIV_STAGES] < {1'b0, dvsr[DIV_STAGES]}) &&
      (remy[DIV_STAGES] < {1'b0, dvsr[DIV_STAGES]}))
    else $error("normal division remainder not below the distance");

endmodule

FILE: sv/cwb_resolve.sv
// ----------------------------------------------------------------------------
// cwb_resolve
// Reflection, position clamp and centre pull, six stages to the output word
// ----------------------------------------------------------------------------
module cwb_resolve (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  cwb_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  input  cwb_pkg::body_t                in_body,
  input  logic                          in_outside,
  input  logic [cwb_pkg::QUOT_W-1:0]    in_qx,
  input  logic [cwb_pkg::QUOT_W-1:0]    in_qy,
  output logic                          out_valid,
  output logic signed [31:0]            new_pos_x,
  output logic signed [31:0]            new_pos_y,
  output logic signed [31:0]            new_vel_x,
  output logic signed [31:0]            new_vel_y,
  output logic                          was_clamped,
  output logic                          was_reflected,
  output logic                          saturated
);
  import cwb_pkg::*;

  localparam logic [QUOT_W-1:0] Q_ONE = QUOT_W'(1 << NORM_BITS);

  // stage 1
  logic [QUOT_W-1:0]  qxc, qyc;
  logic signed [31:0] nx_c, ny_c;
  logic               vld1, out1;
  body_t              bd1;
  logic signed [31:0] nx1, ny1;
  logic signed [63:0] mvx, mvy;
  logic signed [64:0] mcx, mcy;

  // stage 2
  logic signed [64:0]      vdot_c;
  logic signed [SAT_W-1:0] cpx_c, cpy_c;
  logic                    vld2, out2, satc2;
  logic signed [31:0]      nx2, ny2, vx2, vy2, fpx2, fpy2;
  logic signed [34:0]      vdot;

  // stage 3
  logic [16:0]        e1;
  logic signed [32:0] dpx, dpy;
  logic               vld3, out3, satc3, refl3;
  logic signed [31:0] nx3, ny3, vx3, vy3, fpx3, fpy3;
  logic [49:0]        kp;
  logic signed [49:0] ppx, ppy;

  // stage 4
  logic [33:0]        k;
  logic               vld4, out4, satc4, refl4;
  logic signed [31:0] vx4, vy4, fpx4, fpy4;
  logic signed [66:0] rx, ry;
  logic signed [17:0] pullx, pully;

  // stage 5
  logic signed [35:0]      rtx, rty;
  logic signed [SAT_W-1:0] vrx_c, vry_c;
  logic                    vld5, out5, sat5, refl5;
  logic signed [31:0]      vrx, vry, fpx5, fpy5;
  logic signed [17:0]      pullx5, pully5;

  // stage 6
  logic signed [SAT_W-1:0] vox_c, voy_c;

  always_comb begin
    qxc  = (in_qx > Q_ONE) ? Q_ONE : in_qx;
    qyc  = (in_qy > Q_ONE) ? Q_ONE : in_qy;
    nx_c = in_body.dx[32] ? -$signed({1'b0, qxc}) : $signed({1'b0, qxc});
    ny_c = in_body.dy[32] ? -$signed({1'b0, qyc}) : $signed({1'b0, qyc});
  end

  always_comb begin
    vdot_c = 65'(mvx) + 65'(mvy);
    cpx_c  = 36'(cfg.center_x) + 36'($signed(mcx[64:30]));
    cpy_c  = 36'(cfg.center_y) + 36'($signed(mcy[64:30]));
    e1     = 17'(17'd65536 + 17'(cfg.bounce_coeff));
    dpx    = 33'(cfg.center_x) - 33'(fpx2);
    dpy    = 33'(cfg.center_y) - 33'(fpy2);
    k      = kp[49:16];
    rtx    = rx[65:30];
    rty    = ry[65:30];
    vrx_c  = 36'(vx4) - 36'(rtx);
    vry_c  = 36'(vy4) - 36'(rty);
    vox_c  = 36'(vrx) + 36'(pullx5);
    voy_c  = 36'(vry) + 36'(pully5);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1      <= 1'b0;
      vld2      <= 1'b0;
      vld3      <= 1'b0;
      vld4      <= 1'b0;
      vld5      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld1      <= in_valid;
      vld2      <= vld1;
      vld3      <= vld2;
      vld4      <= vld3;
      vld5      <= vld4;
      out_valid <= vld5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // products against the normal
      bd1  <= in_body;
      out1 <= in_outside;
      nx1  <= nx_c;
      ny1  <= ny_c;
      mvx  <= 64'(in_body.vx) * 64'(nx_c);
      mvy  <= 64'(in_body.vy) * 64'(ny_c);
      mcx  <= 65'(nx_c) * 65'(in_body.maxd);
      mcy  <= 65'(ny_c) * 65'(in_body.maxd);

      // outward speed and clamped position
      out2  <= out1;
      nx2   <= nx1;
      ny2   <= ny1;
      vx2   <= bd1.vx;
      vy2   <= bd1.vy;
      vdot  <= vdot_c[64:30];
      fpx2  <= out1 ? sat32(cpx_c) : bd1.px;
      fpy2  <= out1 ? sat32(cpy_c) : bd1.py;
      satc2 <= out1 && (ovf32(cpx_c) || ovf32(cpy_c));

      // restitution scale and pull products
      out3  <= out2;
      satc3 <= satc2;
      refl3 <= out2 && (vdot > 35'sd0);
      nx3   <= nx2;
      ny3   <= ny2;
      vx3   <= vx2;
      vy3   <= vy2;
      fpx3  <= fpx2;
      fpy3  <= fpy2;
      kp    <= 50'(e1) * 50'(vdot[32:0]);
      ppx   <= 50'(dpx) * 50'($signed({1'b0, cfg.centre_pull}));
      ppy   <= 50'(dpy) * 50'($signed({1'b0, cfg.centre_pull}));

      // reflection products
      out4  <= out3;
      satc4 <= satc3;
      refl4 <= refl3;
      vx4   <= vx3;
      vy4   <= vy3;
      fpx4  <= fpx3;
      fpy4  <= fpy3;
      rx    <= 67'(nx3) * 67'($signed({1'b0, k}));
      ry    <= 67'(ny3) * 67'($signed({1'b0, k}));
      pullx <= ppx[49:32];
      pully <= ppy[49:32];

      // reflected velocity
      out5   <= out4;
      refl5  <= refl4;
      sat5   <= satc4 || (refl4 && (ovf32(vrx_c) || ovf32(vry_c)));
      vrx    <= refl4 ? sat32(vrx_c) : vx4;
      vry    <= refl4 ? sat32(vry_c) : vy4;
      fpx5   <= fpx4;
      fpy5   <= fpy4;
      pullx5 <= pullx;
      pully5 <= pully;

      // output word
      new_pos_x     <= fpx5;
      new_pos_y     <= fpy5;
      new_vel_x     <= sat32(vox_c);
      new_vel_y     <= sat32(voy_c);
      was_clamped   <= out5;
      was_reflected <= refl5;
      saturated     <= sat5 || ovf32(vox_c) || ovf32(voy_c);
    end
  end

  a_refl_needs_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid && was_reflected |-> was_clamped)
    else $error("reflection flagged on a body that was not clamped");

  a_inside_keeps_pos: assert property (@(posedge clk) disable iff (rst)
    en && vld1 && !out1 |=> fpx2 == $past(bd1.px) && fpy2 == $past(bd1.py) && !satc2)
    else $error("position changed for a body inside the bound");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks circular_wall_bounce against a bit-exact predictor of the wall
// clamp, reflection and centre pull, over several register settings, random
// handshake idling on both channels and a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import cwb_pkg::*;

  localparam int NUM_REGS = 5;
  localparam int MAX_IDX  = (1 << CFG_IDX_W) - 1;
  localparam int LATENCY  = 74;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               clamped;
    logic               reflected;
    logic               sat;
  } bounce_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] pos_x = '0, pos_y = '0, vel_x = '0, vel_y = '0;
  logic [30:0]        body_radius = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] new_pos_x, new_pos_y, new_vel_x, new_vel_y;
  logic               was_clamped, was_reflected, saturated;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  // predictor copy of the registers
  longint             wall_cx, wall_cy, wall_r, bounce_e, pull_g;

  bounce_t            expected_words[$];
  int                 send_idle, recv_idle, hold_off;
  int                 mismatches, words_seen, n_clamped, n_reflected, n_sat;

  circular_wall_bounce dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint sat_word(longint v, ref bit flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint unit_comp(longint d, longint rdist);
    longint unsigned q;
    longint unsigned m;
    m = (d < 0) ? longint'(-d) : longint'(d);
    q = (m << NORM_BITS) / longint'(rdist);
    if (q > (64'd1 << NORM_BITS)) q = 64'd1 << NORM_BITS;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic bounce_t predict_bounce(logic signed [31:0] ipx, logic signed [31:0] ipy,
                                             logic signed [31:0] ivx, logic signed [31:0] ivy,
                                             logic [30:0] ibr);
    longint px, py, vx, vy, dx, dy, rdist, maxd, nx, ny, vdot, k;
    logic [67:0] ax, ay, s, r, c;
    bit sat;
    bounce_t o;
    px = ipx; py = ipy; vx = ivx; vy = ivy;
    sat = 1'b0;
    o = '0;
    dx = px - wall_cx;
    dy = py - wall_cy;
    ax = (dx < 0) ? 68'(-dx) : 68'(dx);
    ay = (dy < 0) ? 68'(-dy) : 68'(dy);
    s = ax * ax + ay * ay;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (68'd1 << b);
      if (c * c <= s) r = c;
    end
    rdist = longint'(r);
    maxd = wall_r - longint'(ibr);
    if (rdist > maxd && rdist > EPS_LSB) begin
      nx = unit_comp(dx, rdist);
      ny = unit_comp(dy, rdist);
      vdot = (vx * nx + vy * ny) >>> NORM_BITS;
      o.clamped = 1'b1;
      if (vdot > 0) begin
        k = ((65536 + bounce_e) * vdot) >>> 16;
        vx = sat_word(vx - ((nx * k) >>> NORM_BITS), sat);
        vy = sat_word(vy - ((ny * k) >>> NORM_BITS), sat);
        o.reflected = 1'b1;
      end
      px = sat_word(wall_cx + ((nx * maxd) >>> NORM_BITS), sat);
      py = sat_word(wall_cy + ((ny * maxd) >>> NORM_BITS), sat);
    end
    vx = sat_word(vx + (((wall_cx - px) * pull_g) >>> 32), sat);
    vy = sat_word(vy + (((wall_cy - py) * pull_g) >>> 32), sat);
    o.px = px[31:0];
    o.py = py[31:0];
    o.vx = vx[31:0];
    o.vy = vy[31:0];
    o.sat = sat;
    return o;
  endfunction

  task automatic send_body(logic signed [31:0] px, logic signed [31:0] py,
                           logic signed [31:0] vx, logic signed [31:0] vy, logic [30:0] br);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    pos_x       <= px;
    pos_y       <= py;
    vel_x       <= vx;
    vel_y       <= vy;
    body_radius <= br;
    expected_words.push_back(predict_bounce(px, py, vx, vy, br));
    do @(posedge clk); while (in_stall);
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx[CFG_IDX_W-1:0];
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CENTER_X:     wall_cx  = longint'($signed(value));
      REG_CENTER_Y:     wall_cy  = longint'($signed(value));
      REG_BOUND_RADIUS: wall_r   = value[30:0];
      REG_BOUNCE_COEFF: bounce_e = value[15:0];
      REG_CENTRE_PULL:  pull_g   = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_world(logic [31:0] cx, logic [31:0] cy, logic [31:0] r,
                           logic [31:0] e, logic [31:0] g);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_BOUND_RADIUS, r);
    write_reg(REG_BOUNCE_COEFF, e);
    write_reg(REG_CENTRE_PULL, g);
  endtask

  function automatic logic signed [31:0] scaled_rand();
    logic signed [31:0] v;
    v = $urandom;
    return v >>> $urandom_range(31);
  endfunction

  task automatic send_random_body();
    logic signed [31:0] px, py;
    logic [30:0] br;
    if ($urandom_range(9) < 2) begin
      px = $urandom;
      py = $urandom;
    end else begin
      px = 32'(wall_cx) + scaled_rand();
      py = 32'(wall_cy) + scaled_rand();
    end
    case ($urandom_range(3))
      0: br = '0;
      1: br = 31'($urandom);
      default: br = 31'($urandom) >> $urandom_range(30);
    endcase
    send_body(px, py, scaled_rand(), scaled_rand(), br);
  endtask

  task automatic test_directed();
    // centre, inside, on and outside the default wall
    send_body(0, 0, 32'sh0001_0000, -32'sh0001_0000, 0);
    send_body(32'sh0010_0000, 32'sh0020_0000, 0, 0, 31'h0001_0000);
    send_body(32'sh03E8_0000, 0, 32'sh0005_0000, 0, 0);
    send_body(32'sh03E8_0001, 0, 32'sh0005_0000, 0, 0);
    send_body(32'sh0500_0000, 32'sh0500_0000, 32'sh0010_0000, 32'sh0003_0000, 0);
    send_body(32'sh0500_0000, -32'sh0500_0000, -32'sh0010_0000, 32'sh0010_0000, 0);
    send_body(-32'sh0600_0000, 32'sh0100_0000, -32'sh0001_0000, 0, 31'h0064_0000);
    send_body(32'sh0000_0001, 0, 0, 0, 31'h7FFF_FFFF);
    send_body(32'sh0100_0000, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF);
    send_body(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
    send_body(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0);
    send_body(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF);
    send_body(32'sh8000_0000, 0, 32'sh7FFF_FFFF, 0, 0);
    send_body(0, 32'sh7FFF_FFFF, 0, -32'sh0000_0001, 0);
    end_burst();
    // far centre makes the pull and clamp saturate; unknown indexes ignored
    for (int i = NUM_REGS; i <= MAX_IDX; i++) write_reg(i, $urandom);
    set_world(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF, 32'hFFFF);
    send_body(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0);
    send_body(0, 0, 0, 0, 0);
    send_body(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0);
    send_body(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 31'h7FFF_FFFF);
    end_burst();
    set_world(0, 0, 0, 0, 0);
    send_body(32'sh0000_0001, 0, 32'sh0001_0000, 0, 0);
    send_body(0, 0, 32'sh0001_0000, 0, 0);
    send_body(-32'sh0000_0001, -32'sh0000_0001, -32'sh0002_0000, 32'sh0001_0000, 0);
    end_burst();
  endtask

  task automatic test_random(int items, int s_idle, int r_idle);
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int i = 0; i < items; i++) send_random_body();
    end_burst();
  endtask

  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    hold_off = 300;
    for (int i = 0; i < 120; i++) send_random_body();
    end_burst();
  endtask

  // receiver stall, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    bounce_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = {new_pos_x, new_pos_y, new_vel_x, new_vel_y, was_clamped, was_reflected, saturated};
      words_seen++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", got);
      end else begin
        want = expected_words.pop_front();
        n_clamped   += want.clamped;
        n_reflected += want.reflected;
        n_sat       += want.sat;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch word %0d: expected %p actual %p",
                                         words_seen, want, got);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    send_idle = 0;
    recv_idle = 0;
    hold_off = 0;
    mismatches = 0;
    words_seen = 0;
    n_clamped = 0;
    n_reflected = 0;
    n_sat = 0;
    wall_cx = 0;
    wall_cy = 0;
    wall_r = 65536000;
    bounce_e = 60948;
    pull_g = 429;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    set_world(32'h0123_4567, 32'hFEDC_BA98, 32'h0400_0000, 32'd30000, 32'd429);
    test_random(260, 36, 69);
    set_world(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF, 32'hFFFF);
    test_random(120, 69, 36);
    set_world($urandom, $urandom, $urandom, $urandom, $urandom);
    test_random(140, 69, 36);
    set_world(0, 0, 32'h7FFF_FFFF, 0, 0);
    test_random(180, 0, 0);
    set_world(0, 0, 65536000, 60948, 429);
    test_backpressure();
    if (expected_words.size() != 0) mismatches++;
    $display("checked %0d words: %0d clamped, %0d reflected, %0d saturated",
             words_seen, n_clamped, n_reflected, n_sat);
    $display("covered register extremes, random idling on both sides and a long output hold");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
